// ----- rtl/hsva_pkg.sv -----
// hsva_pkg: shared constants, codes and the queue item type of the HSV adjust to RGB block.
// No dependencies; imported by every module of the block.
package hsva_pkg;

  // Channel format: unsigned Q1.ChBits, ChW bits wide so that 1.0 fits
  localparam int unsigned ChBits = 12;
  localparam int unsigned ChW    = ChBits + 1;
  localparam logic [ChW-1:0] ChOne = {1'b1, {ChBits{1'b0}}};

  // Hue in 1/64 degree: full circle and one sixth of it
  localparam int unsigned HueW    = 15;
  localparam int unsigned HueFull = 23040;
  localparam int unsigned HueSeg  = 3840;
  localparam int unsigned FracW   = 12;

  // Configuration registers
  localparam int unsigned ShiftW   = 15;
  localparam int unsigned GainW    = 16;
  localparam int unsigned GainFrac = 12;
  localparam logic [GainW-1:0] GainOne = GainW'(1) << GainFrac;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  // Depth of the queue between front and back
  localparam int unsigned QueueDepth = 4;

  typedef enum logic [CfgIdxW-1:0] {
    CfgHueShift = 2'd0,
    CfgSatGain  = 2'd1,
    CfgValGain  = 2'd2
  } cfg_idx_e;

  // Sixth of the hue circle the pixel falls in
  typedef enum logic [2:0] {
    SegRedYellow    = 3'd0,
    SegYellowGreen  = 3'd1,
    SegGreenCyan    = 3'd2,
    SegCyanBlue     = 3'd3,
    SegBlueMagenta  = 3'd4,
    SegMagentaRed   = 3'd5
  } hue_seg_e;

  // Adjusted and classified pixel, as it waits between front and back
  typedef struct packed {
    hue_seg_e           seg;
    logic [FracW-1:0]   frac;
    logic [ChW-1:0]     sat;
    logic [ChW-1:0]     val;
    logic [ChW-1:0]     alpha;
  } hsva_item_t;

endpackage

// ----- rtl/hsv_adjust_to_rgb.sv -----
// hsv_adjust_to_rgb: throughput is one pixel per cycle while no result waits unread; the
// front register, a 4-deep queue and a four-stage back pipeline each move one beat per
// cycle, and the back stalls only on an unread result.
// Reset clears the queue and all valid flags and loads hue shift 0 and both gains 1.0.
// Depends on hsva_pkg, hsva_front, hsva_queue and hsva_back.
module hsv_adjust_to_rgb (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [hsva_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [hsva_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          push,
  output logic                          full,
  input  logic [hsva_pkg::HueW-1:0]     hue_i,
  input  logic [hsva_pkg::ChW-1:0]      saturation_i,
  input  logic [hsva_pkg::ChW-1:0]      brightness_i,
  input  logic [hsva_pkg::ChW-1:0]      alpha_in_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [hsva_pkg::ChW-1:0]      red_o,
  output logic [hsva_pkg::ChW-1:0]      green_o,
  output logic [hsva_pkg::ChW-1:0]      blue_o,
  output logic [hsva_pkg::ChW-1:0]      alpha_out_o
);
  import hsva_pkg::*;

  logic       fq_vld, fq_full, qb_pop, qb_empty;
  hsva_item_t fq_item, qb_item;

  // Configuration is always taken
  assign cfg_ready = 1'b1;

  hsva_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_wr_i     (cfg_valid),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .push_i       (push),
    .full_o       (full),
    .hue_i        (hue_i),
    .saturation_i (saturation_i),
    .brightness_i (brightness_i),
    .alpha_in_i   (alpha_in_i),
    .item_vld_o   (fq_vld),
    .item_o       (fq_item),
    .item_full_i  (fq_full)
  );

  hsva_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fq_vld),
    .wdata_i (fq_item),
    .full_o  (fq_full),
    .pop_i   (qb_pop),
    .rdata_o (qb_item),
    .empty_o (qb_empty)
  );

  hsva_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_empty_i (qb_empty),
    .item_i       (qb_item),
    .item_pop_o   (qb_pop),
    .empty        (empty),
    .pop          (pop),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o),
    .alpha_out_o  (alpha_out_o)
  );

endmodule

// ----- rtl/hsva_front.sv -----
// hsva_front: configuration registers, hue rotation and wrap, gain and clamp, segment split.
// Depends on hsva_pkg; feeds hsva_queue.
module hsva_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_wr_i,
  input  logic [hsva_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [hsva_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         push_i,
  output logic                         full_o,
  input  logic [hsva_pkg::HueW-1:0]    hue_i,
  input  logic [hsva_pkg::ChW-1:0]     saturation_i,
  input  logic [hsva_pkg::ChW-1:0]     brightness_i,
  input  logic [hsva_pkg::ChW-1:0]     alpha_in_i,
  output logic                         item_vld_o,
  output hsva_pkg::hsva_item_t         item_o,
  input  logic                         item_full_i
);
  import hsva_pkg::*;

  localparam int unsigned SumW  = HueW + 2;
  localparam int unsigned ProdW = ChW + GainW;
  localparam int unsigned SclW  = ProdW - GainFrac;

  logic [ShiftW-1:0] hue_shift_q;
  logic [GainW-1:0]  sat_gain_q, val_gain_q;

  logic [SumW-1:0]   hue_sum;
  logic [HueW-1:0]   hue_wrap;
  logic [ProdW-1:0]  sat_prod, val_prod;
  logic [SclW-1:0]   sat_scl, val_scl;
  logic [ChW-1:0]    sat_adj, val_adj;

  logic              f1_vld_q;
  logic              f1_adv;
  logic [HueW-1:0]   hue_q;
  logic [ChW-1:0]    sat_q, val_q, alpha_q;

  hue_seg_e          seg;
  logic [HueW-1:0]   seg_base;

  // Hold configuration; writes to unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hue_shift_q <= '0;
      sat_gain_q  <= GainOne;
      val_gain_q  <= GainOne;
    end else if (cfg_wr_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgHueShift: hue_shift_q <= cfg_data_i[ShiftW-1:0];
        CfgSatGain:  sat_gain_q  <= cfg_data_i[GainW-1:0];
        CfgValGain:  val_gain_q  <= cfg_data_i[GainW-1:0];
        default: ;
      endcase
    end
  end

  // Rotate hue; the biased sum is never negative and below four full turns
  assign hue_sum = SumW'(hue_i) + {{(SumW-ShiftW){hue_shift_q[ShiftW-1]}}, hue_shift_q}
                 + SumW'(HueFull);

  always_comb begin
    if (hue_sum >= SumW'(3 * HueFull)) begin
      hue_wrap = HueW'(hue_sum - SumW'(3 * HueFull));
    end else if (hue_sum >= SumW'(2 * HueFull)) begin
      hue_wrap = HueW'(hue_sum - SumW'(2 * HueFull));
    end else if (hue_sum >= SumW'(HueFull)) begin
      hue_wrap = HueW'(hue_sum - SumW'(HueFull));
    end else begin
      hue_wrap = HueW'(hue_sum);
    end
  end

  // Scale saturation and value, clamp to 1.0
  assign sat_prod = ProdW'(saturation_i) * ProdW'(sat_gain_q);
  assign val_prod = ProdW'(brightness_i) * ProdW'(val_gain_q);
  assign sat_scl  = sat_prod[ProdW-1:GainFrac];
  assign val_scl  = val_prod[ProdW-1:GainFrac];
  assign sat_adj  = (sat_scl > SclW'(ChOne)) ? ChOne : sat_scl[ChW-1:0];
  assign val_adj  = (val_scl > SclW'(ChOne)) ? ChOne : val_scl[ChW-1:0];

  // Advance the front register whenever the queue can take its beat
  assign f1_adv = !f1_vld_q || !item_full_i;
  assign full_o = !f1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_vld_q <= 1'b0;
    end else if (f1_adv) begin
      f1_vld_q <= push_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && f1_adv) begin
      hue_q   <= hue_wrap;
      sat_q   <= sat_adj;
      val_q   <= val_adj;
      alpha_q <= alpha_in_i;
    end
  end

  // Split the wrapped hue into segment and fraction
  always_comb begin
    if (hue_q >= HueW'(5 * HueSeg)) begin
      seg = SegMagentaRed;
      seg_base = HueW'(5 * HueSeg);
    end else if (hue_q >= HueW'(4 * HueSeg)) begin
      seg = SegBlueMagenta;
      seg_base = HueW'(4 * HueSeg);
    end else if (hue_q >= HueW'(3 * HueSeg)) begin
      seg = SegCyanBlue;
      seg_base = HueW'(3 * HueSeg);
    end else if (hue_q >= HueW'(2 * HueSeg)) begin
      seg = SegGreenCyan;
      seg_base = HueW'(2 * HueSeg);
    end else if (hue_q >= HueW'(HueSeg)) begin
      seg = SegYellowGreen;
      seg_base = HueW'(HueSeg);
    end else begin
      seg = SegRedYellow;
      seg_base = '0;
    end
  end

  assign item_vld_o   = f1_vld_q;
  assign item_o.seg   = seg;
  assign item_o.frac  = FracW'(hue_q - seg_base);
  assign item_o.sat   = sat_q;
  assign item_o.val   = val_q;
  assign item_o.alpha = alpha_q;

  // A held beat stays in the front register until the queue takes it
  a_front_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    f1_vld_q && item_full_i |=> f1_vld_q && $stable(hue_q) && $stable(val_q))
    else $error("front register dropped a stalled pixel");

endmodule

// ----- rtl/hsva_queue.sv -----
// hsva_queue: short FIFO of classified pixels between front and back.
// Depends on hsva_pkg for the item type and depth.
module hsva_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  hsva_pkg::hsva_item_t wdata_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output hsva_pkg::hsva_item_t rdata_o,
  output logic                 empty_o
);
  import hsva_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  hsva_item_t      mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  // Store the incoming beat
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  // Advance pointers and track fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(QueueDepth))
    else $error("queue fill level beyond depth");

  // A beat offered to a full queue is held off, not written
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && full_o && !do_pop |=> cnt_q == CntW'(QueueDepth))
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from an empty queue");

endmodule

// ----- rtl/hsva_back.sv -----
// hsva_back: four-stage pipeline that turns a classified HSV pixel into RGB.
// Depends on hsva_pkg; pulls from hsva_queue and holds the result register.
module hsva_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 item_empty_i,
  input  hsva_pkg::hsva_item_t item_i,
  output logic                 item_pop_o,
  output logic                 empty,
  input  logic                 pop,
  output logic [hsva_pkg::ChW-1:0] red_o,
  output logic [hsva_pkg::ChW-1:0] green_o,
  output logic [hsva_pkg::ChW-1:0] blue_o,
  output logic [hsva_pkg::ChW-1:0] alpha_out_o
);
  import hsva_pkg::*;

  // Divide by ONE*3840 as a shift by ChBits+8 and a divide by 15 through a reciprocal
  localparam int unsigned VsW      = 2 * ChW;
  localparam int unsigned FProdW   = VsW + FracW;
  localparam int unsigned ZW       = ChBits + 4;
  localparam int unsigned ZLsb     = ChBits + 8;
  localparam int unsigned RecipSh  = ZW + 4;
  localparam int unsigned RecipMul = ((1 << RecipSh) + 14) / 15;
  localparam int unsigned MulW     = ZW + RecipSh;

  logic adv;

  // Stage 1: v*s
  logic             vld1_q;
  hue_seg_e         seg1_q;
  logic [FracW-1:0] frac1_q;
  logic [ChW-1:0]   val1_q, alpha1_q;
  logic [VsW-1:0]   vs1_q;

  // Stage 2: v*s*f and v*s*(1-f) scaled down, p
  logic             vld2_q;
  hue_seg_e         seg2_q;
  logic [ChW-1:0]   val2_q, alpha2_q, p2_q;
  logic [ZW-1:0]    zq2_q, zt2_q;
  logic [FProdW-1:0] fq_prod, ft_prod;

  // Stage 3: divide by 15; the quotient reaches 1.0 when v and s are both 1.0
  logic             vld3_q;
  hue_seg_e         seg3_q;
  logic [ChW-1:0]   val3_q, alpha3_q, p3_q;
  logic [ChW-1:0]   dq3_q, dt3_q;
  logic [MulW-1:0]  rq_prod, rt_prod;

  // Output register
  logic             out_vld_q;
  logic [ChW-1:0]   q_val, t_val;
  logic [ChW-1:0]   red_q, green_q, blue_q, alpha_q;

  // Stall the whole pipeline only while a result waits unread
  assign adv        = !out_vld_q || pop;
  assign item_pop_o = adv && !item_empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q    <= 1'b0;
      vld2_q    <= 1'b0;
      vld3_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld1_q    <= !item_empty_i;
      vld2_q    <= vld1_q;
      vld3_q    <= vld2_q;
      out_vld_q <= vld3_q;
    end
  end

  assign fq_prod = FProdW'(vs1_q) * FProdW'(frac1_q);
  assign ft_prod = FProdW'(vs1_q) * FProdW'(FracW'(HueSeg) - frac1_q);
  assign rq_prod = MulW'(zq2_q) * MulW'(RecipMul);
  assign rt_prod = MulW'(zt2_q) * MulW'(RecipMul);
  assign q_val   = val3_q - dq3_q;
  assign t_val   = val3_q - dt3_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      // Stage 1
      seg1_q   <= item_i.seg;
      frac1_q  <= item_i.frac;
      val1_q   <= item_i.val;
      alpha1_q <= item_i.alpha;
      vs1_q    <= VsW'(item_i.val) * VsW'(item_i.sat);
      // Stage 2
      seg2_q   <= seg1_q;
      val2_q   <= val1_q;
      alpha2_q <= alpha1_q;
      p2_q     <= val1_q - vs1_q[ChBits +: ChW];
      zq2_q    <= fq_prod[ZLsb +: ZW];
      zt2_q    <= ft_prod[ZLsb +: ZW];
      // Stage 3
      seg3_q   <= seg2_q;
      val3_q   <= val2_q;
      alpha3_q <= alpha2_q;
      p3_q     <= p2_q;
      dq3_q    <= rq_prod[RecipSh +: ChW];
      dt3_q    <= rt_prod[RecipSh +: ChW];
      // Output: pick channels by segment
      alpha_q  <= alpha3_q;
      case (seg3_q)
        SegRedYellow: begin
          red_q <= val3_q; green_q <= t_val;  blue_q <= p3_q;
        end
        SegYellowGreen: begin
          red_q <= q_val;  green_q <= val3_q; blue_q <= p3_q;
        end
        SegGreenCyan: begin
          red_q <= p3_q;   green_q <= val3_q; blue_q <= t_val;
        end
        SegCyanBlue: begin
          red_q <= p3_q;   green_q <= q_val;  blue_q <= val3_q;
        end
        SegBlueMagenta: begin
          red_q <= t_val;  green_q <= p3_q;   blue_q <= val3_q;
        end
        default: begin
          red_q <= val3_q; green_q <= p3_q;   blue_q <= q_val;
        end
      endcase
    end
  end

  assign empty       = !out_vld_q;
  assign red_o       = red_q;
  assign green_o     = green_q;
  assign blue_o      = blue_q;
  assign alpha_out_o = alpha_q;

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable({vld1_q, vld2_q, vld3_q, out_vld_q}))
    else $error("pipeline moved while the result was stalled");

  a_pull_on_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_pop_o |=> vld1_q)
    else $error("pixel taken from the queue was lost");

endmodule

// ----- bench/hsv_adjust_to_rgb_tb.sv -----
// hsv_adjust_to_rgb_tb: self-checking bench for the HSV adjust to RGB converter.
// A directed table and then random phases under several register settings, each result
// checked against a table value or predictor. Depends on hsva_pkg and hsv_adjust_to_rgb.
module hsv_adjust_to_rgb_tb;
  import hsva_pkg::*;

  localparam int NumRows       = 32;
  localparam int NumPhases     = 8;
  localparam int ItemsPerPhase = 200;
  localparam int HoldCycles    = 80;
  localparam int DrainCycles   = 12;
  localparam int WatchLimit    = 1000;
  localparam int ShiftSpan     = 11520;
  localparam int ChMax         = (1 << ChW) - 1;
  localparam int HueMax        = (1 << HueW) - 1;
  localparam longint unsigned SegDen = longint'(ChOne) * HueSeg;
  // Index that maps to no register
  localparam logic [CfgIdxW-1:0] CfgNoReg = 2'd3;

  typedef enum logic {RowPixel, RowWrite} row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    logic [CfgIdxW-1:0] idx;
    logic [CfgDataW-1:0] data;
    logic [HueW-1:0]    hue;
    logic [ChW-1:0]     sat;
    logic [ChW-1:0]     val;
    logic [ChW-1:0]     alpha;
    logic               typed;
    logic [ChW-1:0]     red;
    logic [ChW-1:0]     green;
    logic [ChW-1:0]     blue;
  } stim_row_t;

  typedef struct packed {
    logic [ChW-1:0] red;
    logic [ChW-1:0] green;
    logic [ChW-1:0] blue;
    logic [ChW-1:0] alpha;
  } rgba_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                push;
  logic                full;
  logic [HueW-1:0]     hue_i;
  logic [ChW-1:0]      saturation_i;
  logic [ChW-1:0]      brightness_i;
  logic [ChW-1:0]      alpha_in_i;
  logic                empty;
  logic                pop;
  logic [ChW-1:0]      red_o;
  logic [ChW-1:0]      green_o;
  logic [ChW-1:0]      blue_o;
  logic [ChW-1:0]      alpha_out_o;

  // Predictor copy of the adjustment registers
  logic signed [ShiftW-1:0] shift_q;
  logic [GainW-1:0]         sat_gain_q;
  logic [GainW-1:0]         val_gain_q;

  rgba_t pixel_queue [$];
  int    n_errors    = 0;
  int    stall_cycles = 0;
  bit    hold_req    = 1'b0;

  hsv_adjust_to_rgb DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .push         (push),
    .full         (full),
    .hue_i        (hue_i),
    .saturation_i (saturation_i),
    .brightness_i (brightness_i),
    .alpha_in_i   (alpha_in_i),
    .empty        (empty),
    .pop          (pop),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o),
    .alpha_out_o  (alpha_out_o)
  );

  function automatic stim_row_t pix(int h, int s, int v, int a);
    stim_row_t row;
    row = '0;
    row.kind  = RowPixel;
    row.hue   = HueW'(h);
    row.sat   = ChW'(s);
    row.val   = ChW'(v);
    row.alpha = ChW'(a);
    return row;
  endfunction

  function automatic stim_row_t pix_exp(int h, int s, int v, int a, int r, int g, int b);
    stim_row_t row;
    row = pix(h, s, v, a);
    row.typed = 1'b1;
    row.red   = ChW'(r);
    row.green = ChW'(g);
    row.blue  = ChW'(b);
    return row;
  endfunction

  function automatic stim_row_t reg_wr(logic [CfgIdxW-1:0] idx, int data);
    stim_row_t row;
    row = '0;
    row.kind = RowWrite;
    row.idx  = idx;
    row.data = CfgDataW'(data);
    return row;
  endfunction

  // Directed part: primaries and secondaries, wrap, grey, clamps, register extremes
  stim_row_t directed_rows [NumRows] = '{
    pix_exp(0,     4096, 4096, 4096, 4096, 0,    0),
    pix_exp(3840,  4096, 4096, 4096, 4096, 4096, 0),
    pix_exp(7680,  4096, 4096, 4096, 0,    4096, 0),
    pix_exp(11520, 4096, 4096, 4096, 0,    4096, 4096),
    pix_exp(15360, 4096, 4096, 4096, 0,    0,    4096),
    pix_exp(19200, 4096, 4096, 4096, 4096, 0,    4096),
    pix_exp(23040, 4096, 4096, 0,    4096, 0,    0),
    pix_exp(5000,  0,    2048, 100,  2048, 2048, 2048),
    pix_exp(0,     0,    0,    0,    0,    0,    0),
    pix(HueMax, ChMax, ChMax, ChMax),
    pix(1920, 4096, 4096, 2048),
    pix(23039, 1, 1, 1),
    pix(12345, 2000, 3000, 1234),
    pix(16384, ChMax, 0, 4095),
    reg_wr(CfgHueShift, ShiftSpan),
    pix_exp(0, 4096, 4096, 4096, 0, 4096, 4096),
    pix(23040, 4096, 2048, 7),
    reg_wr(CfgHueShift, -ShiftSpan),
    pix_exp(0, 4096, 4096, 4096, 0, 4096, 4096),
    pix(HueMax, 3000, 3500, ChMax),
    reg_wr(CfgSatGain, 0),
    pix_exp(7000, 4096, 3000, 4096, 3000, 3000, 3000),
    reg_wr(CfgSatGain, 65535),
    pix(7000, 1, 3000, 0),
    reg_wr(CfgValGain, 0),
    pix_exp(7000, 4096, 4096, 0, 0, 0, 0),
    reg_wr(CfgValGain, 65535),
    pix(9000, 300, 300, 5),
    reg_wr(CfgNoReg, 0),
    pix(9000, 300, 300, 5),
    reg_wr(CfgHueShift, 'h7FFF),
    pix(0, 4096, 4096, 4096)
  };

  function automatic longint unsigned scale_gain(logic [ChW-1:0] x, logic [GainW-1:0] gain);
    longint unsigned prod;
    prod = (longint'(x) * longint'(gain)) >> GainFrac;
    return (prod > ChOne) ? longint'(ChOne) : prod;
  endfunction

  // Predict the RGBA pixel for one HSVA pixel under the current registers
  function automatic rgba_t convert_pixel(logic [HueW-1:0] h, logic [ChW-1:0] s,
                                          logic [ChW-1:0] v, logic [ChW-1:0] a);
    int              hue_sum;
    int              hue_adj;
    hue_seg_e        seg;
    longint unsigned frac, sat, val, vs, p, q, t, r, g, b;
    rgba_t           res;
    hue_sum = int'(h) + int'(shift_q) + int'(HueFull);
    hue_adj = hue_sum % int'(HueFull);
    sat = scale_gain(s, sat_gain_q);
    val = scale_gain(v, val_gain_q);
    seg  = hue_seg_e'(hue_adj / int'(HueSeg));
    frac = longint'(hue_adj % int'(HueSeg));
    vs = val * sat;
    p = val - vs / ChOne;
    q = val - (vs * frac) / SegDen;
    t = val - (vs * (HueSeg - frac)) / SegDen;
    if (sat == 0) begin
      r = val; g = val; b = val;
    end else begin
      case (seg)
        SegRedYellow:   begin r = val; g = t;   b = p;   end
        SegYellowGreen: begin r = q;   g = val; b = p;   end
        SegGreenCyan:   begin r = p;   g = val; b = t;   end
        SegCyanBlue:    begin r = p;   g = q;   b = val; end
        SegBlueMagenta: begin r = t;   g = p;   b = val; end
        default:        begin r = val; g = p;   b = q;   end
      endcase
    end
    res.red   = ChW'(r);
    res.green = ChW'(g);
    res.blue  = ChW'(b);
    res.alpha = a;
    return res;
  endfunction

  function automatic logic [ChW-1:0] draw_channel();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return '0;
    if (pick == 1) return ChOne;
    if (pick < 4) return ChW'($urandom_range(0, ChMax));
    return ChW'($urandom_range(0, ChOne));
  endfunction

  function automatic void check_field(string name, logic [ChW-1:0] want, logic [ChW-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_errors++;
    end
  endfunction

  // Write one register and mirror it into the predictor; call at a rising edge
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid   <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
    case (idx)
      CfgHueShift: shift_q    = data[ShiftW-1:0];
      CfgSatGain:  sat_gain_q = data;
      CfgValGain:  val_gain_q = data;
      default: ;
    endcase
    // Leave the interface idle so the next beat starts on a later edge
    @(posedge clk_i);
  endtask

  // Drop push and hold until every pixel in flight has come back
  task automatic wait_idle();
    push <= 1'b0;
    while (pixel_queue.size() != 0) @(posedge clk_i);
  endtask

  // Offer one pixel after a random or no gap; queue its expected result on acceptance
  task automatic send_pixel(input logic [HueW-1:0] h, input logic [ChW-1:0] s,
                            input logic [ChW-1:0] v, input logic [ChW-1:0] a,
                            input bit typed, input rgba_t typed_val, input bit steady);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push         <= 1'b1;
    hue_i        <= h;
    saturation_i <= s;
    brightness_i <= v;
    alpha_in_i   <= a;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    if (typed) pixel_queue.push_back(typed_val);
    else pixel_queue.push_back(convert_pixel(h, s, v, a));
  endtask

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Check each result beat against the oldest prediction; watch for a hang
  always @(posedge clk_i) begin : check_results
    rgba_t want;
    if (rst_ni) begin
      if (pop && !empty) begin
        if (pixel_queue.size() == 0) begin
          $error("result beat with no pixel outstanding");
          n_errors++;
        end else begin
          want = pixel_queue.pop_front();
          check_field("red", want.red, red_o);
          check_field("green", want.green, green_o);
          check_field("blue", want.blue, blue_o);
          check_field("alpha_out", want.alpha, alpha_out_o);
        end
      end
      if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= WatchLimit) begin
        $display("[hsv_adjust_to_rgb] ERROR");
        $finish;
      end
    end
  end

  // Result side: random pop gaps, steady stretches, one long hold-off on request
  initial begin
    int unsigned wait_cycles;
    int unsigned beat_count;
    beat_count = 0;
    pop <= 1'b0;
    @(posedge clk_i);
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      if (hold_req) begin
        pop <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        wait_cycles = ((beat_count / 64) % 4 == 1) ? 0 : $urandom_range(0, 4);
        if (wait_cycles != 0) begin
          pop <= 1'b0;
          repeat (wait_cycles) @(posedge clk_i);
        end
      end
      pop <= 1'b1;
      @(posedge clk_i);
      while (empty) @(posedge clk_i);
      beat_count++;
    end
  end

  // Stimulus: reset, directed table, random phases, drain
  initial begin
    stim_row_t           row;
    rgba_t               typed_val;
    logic [CfgDataW-1:0] shift_w, sat_w, val_w;
    logic [HueW-1:0]     hue_w;
    rst_ni       <= 1'b0;
    cfg_valid    <= 1'b0;
    cfg_index_i  <= CfgHueShift;
    cfg_data_i   <= '0;
    push         <= 1'b0;
    hue_i        <= '0;
    saturation_i <= '0;
    brightness_i <= '0;
    alpha_in_i   <= '0;
    shift_q    = '0;
    sat_gain_q = GainOne;
    val_gain_q = GainOne;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table
    for (int i = 0; i < NumRows; i++) begin
      row = directed_rows[i];
      if (row.kind == RowWrite) begin
        wait_idle();
        write_reg(row.idx, row.data);
      end else begin
        typed_val.red   = row.red;
        typed_val.green = row.green;
        typed_val.blue  = row.blue;
        typed_val.alpha = row.alpha;
        send_pixel(row.hue, row.sat, row.val, row.alpha, row.typed, typed_val, 1'b0);
      end
    end

    // Random phases, each under its own register setting
    for (int phase = 0; phase < NumPhases; phase++) begin
      wait_idle();
      case (phase)
        0: begin shift_w = '0; sat_w = GainOne; val_w = GainOne; end
        1: begin shift_w = CfgDataW'(ShiftSpan); sat_w = '1; val_w = '1; end
        2: begin shift_w = CfgDataW'(-ShiftSpan); sat_w = '0; val_w = GainOne; end
        default: begin
          shift_w = CfgDataW'($urandom_range(0, 65535));
          sat_w = $urandom_range(0, 1) ? CfgDataW'($urandom_range(0, 2 * GainOne))
                                       : CfgDataW'($urandom_range(0, 65535));
          val_w = $urandom_range(0, 1) ? CfgDataW'($urandom_range(0, 2 * GainOne))
                                       : CfgDataW'($urandom_range(0, 65535));
        end
      endcase
      write_reg(CfgHueShift, shift_w);
      write_reg(CfgSatGain, sat_w);
      write_reg(CfgValGain, val_w);
      if (phase % 2 == 1) write_reg(CfgNoReg, CfgDataW'($urandom_range(0, 65535)));
      for (int n = 0; n < ItemsPerPhase; n++) begin
        // Stall the result side once so the queue fills and full asserts
        if (phase == 3 && n == 40) hold_req = 1'b1;
        hue_w = ($urandom_range(0, 4) == 0) ? HueW'($urandom_range(0, HueMax))
                                           : HueW'($urandom_range(0, HueFull));
        send_pixel(hue_w, draw_channel(), draw_channel(), ChW'($urandom_range(0, ChMax)),
                   1'b0, '0, (n / 50) % 4 == 3);
      end
    end

    wait_idle();
    repeat (DrainCycles) @(posedge clk_i);
    if (n_errors == 0 && pixel_queue.size() == 0) begin
      $display("[hsv_adjust_to_rgb] OK");
    end else begin
      $display("[hsv_adjust_to_rgb] ERROR");
    end
    $finish;
  end

endmodule
